// File: hw/rtl/svdc_pkg.sv
package svdc_pkg;

   localparam int VECTOR_WIDTH = 16;
   localparam int DUTY_WIDTH   = 16;

   // phases carry sixteen guard bits below the input fraction
   localparam int GUARD_BITS = 16;
   localparam int PHASE_FRAC = VECTOR_WIDTH - 3 + GUARD_BITS;
   localparam int CONST_W    = 31;
   localparam int PROD_SHIFT = CONST_W - 1 - GUARD_BITS;
   localparam int PROD_W     = VECTOR_WIDTH + CONST_W + 1;
   localparam int PH_W       = VECTOR_WIDTH + GUARD_BITS + 2;
   localparam int DIV_W      = PH_W + 2;
   localparam int QBITS      = DUTY_WIDTH + 1;
   localparam int NUM_PHASES = 3;

   // sqrt(3)/2 in Q1.30
   localparam logic signed [CONST_W:0] HALF_ROOT3_Q30 = (CONST_W + 1)'(929887697);

   typedef logic signed [VECTOR_WIDTH-1:0] vector_type;
   typedef logic [DUTY_WIDTH-1:0]          duty_type;
   typedef logic signed [PROD_W-1:0]       prod_type;
   typedef logic signed [PH_W-1:0]         phase_type;
   typedef logic signed [DIV_W-1:0]        centred_type;
   typedef logic [DIV_W-1:0]               divw_type;
   typedef logic [QBITS-1:0]               quot_type;
   typedef logic [QBITS:0]                 round_type;

endpackage

// File: hw/rtl/svdc_req_if.sv
interface svdc_req_if;
   logic                   valid;
   logic                   ready;
   svdc_pkg::vector_type   alpha_component;
   svdc_pkg::vector_type   beta_component;

   modport source (output valid, output alpha_component, output beta_component, input ready);
   modport sink (input valid, input alpha_component, input beta_component, output ready);
endinterface

// File: hw/rtl/svdc_rsp_if.sv
interface svdc_rsp_if;
   logic                 valid;
   logic                 ready;
   svdc_pkg::duty_type   duty_phase_a;
   svdc_pkg::duty_type   duty_phase_b;
   svdc_pkg::duty_type   duty_phase_c;
   logic                 span_limited;

   modport source (output valid, output duty_phase_a, output duty_phase_b,
                   output duty_phase_c, output span_limited, input ready);
   modport sink (input valid, input duty_phase_a, input duty_phase_b,
                 input duty_phase_c, input span_limited, output ready);
endinterface

// File: hw/rtl/space_vector_duty_calculator_unit.sv
// Space vector duty calculator with min-max common-mode injection.
// Request channel (req_if): one alpha/beta voltage vector, signed Q2.13.
// Response channel (rsp_if): three unsigned Q0.16 duty ratios and a flag
// that is set when the phase span exceeded 1.0 and all phases were scaled.
// Both channels use valid/ready; a transfer happens on a clock edge where
// both are high.
// Throughput: one request per cycle while the receiver does not stall the
// output. A request passes through four front stages (multiply, phases,
// min/max, centring), one magnitude stage, the 17-step pipelined restoring
// divider (one quotient bit per stage, three phases side by side) and the
// output register.
// When the receiver holds rsp_if.ready low with a response waiting, the
// whole pipeline freezes and req_if.ready drops in the same cycle; nothing
// in flight is lost or repeated. req_if.ready is high whenever the output
// register is empty or being emptied.
// Synchronous reset clears every stage's valid bit; responses in flight are
// dropped. The block keeps no state between requests.
module space_vector_duty_calculator_unit (
   input logic           clock,
   input logic           reset,
   svdc_req_if.sink      req_if,
   svdc_rsp_if.source    rsp_if
);

   localparam int NP = svdc_pkg::NUM_PHASES;
   localparam int QB = svdc_pkg::QBITS;

   logic advance;

   // stage 1: beta times sqrt(3)/2
   logic                   s1_valid_ff;
   svdc_pkg::vector_type   s1_alpha_ff;
   svdc_pkg::prod_type     s1_prod_ff;
   svdc_pkg::prod_type     s1_prod_in;

   // stage 2: three phase references
   logic                   s2_valid_ff;
   svdc_pkg::phase_type    s2_ph_ff [NP];
   svdc_pkg::phase_type    s2_ph_in [NP];
   svdc_pkg::prod_type     rnd_sum;
   svdc_pkg::phase_type    rot;
   svdc_pkg::phase_type    alpha_ext;
   svdc_pkg::phase_type    alpha_half;

   // stage 3: largest and smallest phase
   logic                   s3_valid_ff;
   svdc_pkg::phase_type    s3_ph_ff [NP];
   svdc_pkg::phase_type    s3_max_ff;
   svdc_pkg::phase_type    s3_min_ff;
   svdc_pkg::phase_type    s3_max_in;
   svdc_pkg::phase_type    s3_min_in;

   // stage 4: doubled centred phases and divisor
   logic                   s4_valid_ff;
   svdc_pkg::centred_type  s4_v2_ff [NP];
   svdc_pkg::centred_type  s4_v2_in [NP];
   svdc_pkg::divw_type     s4_div_ff;
   svdc_pkg::divw_type     s4_div_in;
   logic                   s4_flag_ff;
   logic                   s4_flag_in;
   svdc_pkg::phase_type    span;
   svdc_pkg::phase_type    unit_one;
   svdc_pkg::centred_type  mm_sum;

   // divider pipeline, index 0 is the magnitude stage
   logic                   div_valid_ff [QB+1];
   svdc_pkg::divw_type     div_rem_ff   [QB+1][NP];
   svdc_pkg::divw_type     div_rem_in   [QB+1][NP];
   svdc_pkg::quot_type     div_q_ff     [QB+1][NP];
   svdc_pkg::quot_type     div_q_in     [QB+1][NP];
   logic [NP-1:0]          div_neg_ff   [QB+1];
   logic [NP-1:0]          div_neg_in;
   svdc_pkg::divw_type     div_d_ff     [QB+1];
   logic                   div_flag_ff  [QB+1];
   svdc_pkg::divw_type     mag          [NP];
   svdc_pkg::divw_type     shifted      [QB+1][NP];

   // output register
   logic                   rsp_valid_ff;
   svdc_pkg::duty_type     duty_ff [NP];
   svdc_pkg::duty_type     duty_in [NP];
   logic                   rsp_flag_ff;
   svdc_pkg::round_type    q_round [NP];
   svdc_pkg::round_type    duty_wide [NP];
   svdc_pkg::round_type    half_q;
   svdc_pkg::round_type    full_q;

   assign advance      = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = advance;

   // ---------------------------------------------------------------- stage 1
   assign s1_prod_in = svdc_pkg::PROD_W'(req_if.beta_component)
                     * svdc_pkg::PROD_W'(svdc_pkg::HALF_ROOT3_Q30);

   // ---------------------------------------------------------------- stage 2
   always_comb begin
      // round half up, toward plus infinity
      rnd_sum    = s1_prod_ff + (svdc_pkg::PROD_W'(1) <<< (svdc_pkg::PROD_SHIFT - 1));
      rot        = svdc_pkg::PH_W'(rnd_sum >>> svdc_pkg::PROD_SHIFT);
      alpha_ext  = svdc_pkg::PH_W'(s1_alpha_ff);
      alpha_half = alpha_ext <<< (svdc_pkg::GUARD_BITS - 1);
      s2_ph_in[0] = alpha_ext <<< svdc_pkg::GUARD_BITS;
      s2_ph_in[1] = rot - alpha_half;
      s2_ph_in[2] = -alpha_half - rot;
   end

   // ---------------------------------------------------------------- stage 3
   always_comb begin
      s3_max_in = s2_ph_ff[0];
      s3_min_in = s2_ph_ff[0];
      for (int k = 1; k < NP; k++) begin
         if (s2_ph_ff[k] > s3_max_in) begin
            s3_max_in = s2_ph_ff[k];
         end
         if (s2_ph_ff[k] < s3_min_in) begin
            s3_min_in = s2_ph_ff[k];
         end
      end
   end

   // ---------------------------------------------------------------- stage 4
   always_comb begin
      span       = s3_max_ff - s3_min_ff;
      unit_one   = svdc_pkg::PH_W'(1) <<< svdc_pkg::PHASE_FRAC;
      s4_flag_in = span > unit_one;
      s4_div_in  = s4_flag_in ? (svdc_pkg::DIV_W'(span) << 1)
                              : (svdc_pkg::DIV_W'(unit_one) << 1);
      mm_sum     = svdc_pkg::DIV_W'(s3_max_ff) + svdc_pkg::DIV_W'(s3_min_ff);
      for (int k = 0; k < NP; k++) begin
         s4_v2_in[k] = (svdc_pkg::DIV_W'(s3_ph_ff[k]) <<< 1) - mm_sum;
      end
   end

   // ------------------------------ magnitude stage and restoring divider
   always_comb begin
      for (int k = 0; k < NP; k++) begin
         div_neg_in[k] = s4_v2_ff[k][svdc_pkg::DIV_W-1];
         mag[k]        = div_neg_in[k] ? svdc_pkg::divw_type'(-s4_v2_ff[k])
                                       : svdc_pkg::divw_type'(s4_v2_ff[k]);
         div_rem_in[0][k] = (mag[k] > s4_div_ff) ? s4_div_ff : mag[k];
         div_q_in[0][k]   = '0;
         shifted[0][k]    = '0;
      end
      for (int s = 1; s <= QB; s++) begin
         for (int k = 0; k < NP; k++) begin
            shifted[s][k] = div_rem_ff[s-1][k] << 1;
            if (shifted[s][k] >= div_d_ff[s-1]) begin
               div_rem_in[s][k] = shifted[s][k] - div_d_ff[s-1];
               div_q_in[s][k]   = {div_q_ff[s-1][k][QB-2:0], 1'b1};
            end else begin
               div_rem_in[s][k] = shifted[s][k];
               div_q_in[s][k]   = {div_q_ff[s-1][k][QB-2:0], 1'b0};
            end
         end
      end
   end

   // --------------------------------------------------------- output stage
   always_comb begin
      half_q = svdc_pkg::round_type'(1) << (svdc_pkg::DUTY_WIDTH - 1);
      full_q = (svdc_pkg::round_type'(1) << svdc_pkg::DUTY_WIDTH) - 1'b1;
      for (int k = 0; k < NP; k++) begin
         // round half away from zero on the magnitude
         q_round[k] = ({1'b0, div_q_ff[QB][k]} + 1'b1) >> 1;
         if (q_round[k] > half_q) begin
            q_round[k] = half_q;
         end
         duty_wide[k] = div_neg_ff[QB][k] ? (half_q - q_round[k]) : (half_q + q_round[k]);
         if (duty_wide[k] > full_q) begin
            duty_wide[k] = full_q;
         end
         duty_in[k] = svdc_pkg::DUTY_WIDTH'(duty_wide[k]);
      end
   end

   // ------------------------------------------------------------ registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s <= QB; s++) begin
            div_valid_ff[s] <= 1'b0;
         end
      end else if (advance) begin
         s1_valid_ff     <= req_if.valid;
         s2_valid_ff     <= s1_valid_ff;
         s3_valid_ff     <= s2_valid_ff;
         s4_valid_ff     <= s3_valid_ff;
         div_valid_ff[0] <= s4_valid_ff;
         for (int s = 1; s <= QB; s++) begin
            div_valid_ff[s] <= div_valid_ff[s-1];
         end
         rsp_valid_ff <= div_valid_ff[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_alpha_ff <= req_if.alpha_component;
         s1_prod_ff  <= s1_prod_in;
         s2_ph_ff    <= s2_ph_in;
         s3_ph_ff    <= s2_ph_ff;
         s3_max_ff   <= s3_max_in;
         s3_min_ff   <= s3_min_in;
         s4_v2_ff    <= s4_v2_in;
         s4_div_ff   <= s4_div_in;
         s4_flag_ff  <= s4_flag_in;

         div_rem_ff[0]  <= div_rem_in[0];
         div_q_ff[0]    <= div_q_in[0];
         div_neg_ff[0]  <= div_neg_in;
         div_d_ff[0]    <= s4_div_ff;
         div_flag_ff[0] <= s4_flag_ff;
         for (int s = 1; s <= QB; s++) begin
            div_rem_ff[s]  <= div_rem_in[s];
            div_q_ff[s]    <= div_q_in[s];
            div_neg_ff[s]  <= div_neg_ff[s-1];
            div_d_ff[s]    <= div_d_ff[s-1];
            div_flag_ff[s] <= div_flag_ff[s-1];
         end

         duty_ff     <= duty_in;
         rsp_flag_ff <= div_flag_ff[QB];
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.duty_phase_a = duty_ff[0];
   assign rsp_if.duty_phase_b = duty_ff[1];
   assign rsp_if.duty_phase_c = duty_ff[2];
   assign rsp_if.span_limited = rsp_flag_ff;

endmodule

// File: hw/rtl/svdc_checker.sv
module svdc_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input svdc_pkg::duty_type   duty_phase_a,
   input svdc_pkg::duty_type   duty_phase_b,
   input svdc_pkg::duty_type   duty_phase_c,
   input logic                 span_limited
);

   localparam svdc_pkg::duty_type DUTY_FULL = '1;
   localparam svdc_pkg::duty_type DUTY_ZERO = '0;

   // a waiting response stays until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // a stalled response keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(duty_phase_a) && $stable(duty_phase_b)
                                  && $stable(duty_phase_c) && $stable(span_limited))
      else $error("response payload changed while stalled");

   // the pipeline takes a request whenever the output register is free
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("request refused with a free output");

   // a scaled vector puts one phase on each rail
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && span_limited |->
         (duty_phase_a == DUTY_FULL || duty_phase_b == DUTY_FULL || duty_phase_c == DUTY_FULL)
         && (duty_phase_a == DUTY_ZERO || duty_phase_b == DUTY_ZERO
             || duty_phase_c == DUTY_ZERO))
      else $error("scaled response does not reach both rails");

   // nothing comes out right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid straight after reset");

endmodule

bind space_vector_duty_calculator_unit svdc_checker u_svdc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_if.ready),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .duty_phase_a (rsp_if.duty_phase_a),
   .duty_phase_b (rsp_if.duty_phase_b),
   .duty_phase_c (rsp_if.duty_phase_c),
   .span_limited (rsp_if.span_limited)
);
